// File: hw/rtl/ahfp_pkg.sv
package ahfp_pkg;

    // Longest line in bytes, newline excluded, is LINE_BUFFER_BYTES - 1.
    localparam int LINE_BUFFER_BYTES = 64;

    localparam int FRAME_TOKENS = 7;
    // Tokens 0..5 carry the frame payload; token 6 carries the CRC.
    localparam int HELD_LANES   = 6;
    localparam int LANE_W       = 3;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_SHORT = 2'd1,
        ERR_CRC   = 2'd2
    } t_err;

    // One decoded token headed for the frame store.
    typedef struct packed {
        logic              we;
        logic [LANE_W-1:0] lane;
        logic [7:0]        data;
    } t_wr_req;

    // Outcome of a completed line.
    typedef struct packed {
        logic fire;
        logic ok;
        t_err err;
    } t_result;

    typedef logic [HELD_LANES-1:0][7:0] t_frame_row;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 4'(c - 8'h61 + 8'd10);
        end
        return d;
    endfunction

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/ahfp_if.sv
interface ahfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ahfp_out_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [1:0]  error_kind;
    logic [7:0]  flags_byte;
    logic [23:0] button_bits;
    logic [7:0]  joystick_one;
    logic [7:0]  joystick_two;

    modport source (
        output valid, output frame_ok, output error_kind, output flags_byte,
        output button_bits, output joystick_one, output joystick_two,
        input ready
    );
    modport sink (
        input valid, input frame_ok, input error_kind, input flags_byte,
        input button_bits, input joystick_one, input joystick_two,
        output ready
    );
endinterface

// File: hw/rtl/ahfp_tokenizer.sv
module ahfp_tokenizer #(
    parameter int LINE_BUFFER_BYTES = ahfp_pkg::LINE_BUFFER_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output ahfp_pkg::t_wr_req o_wr,
    output ahfp_pkg::t_result o_res
);

    localparam int LCW = $clog2(LINE_BUFFER_BYTES);
    localparam logic [LCW-1:0] LINE_MAX = LCW'(LINE_BUFFER_BYTES - 1);

    logic [LCW-1:0] r_line_count, n_line_count;
    logic           r_nul_seen, n_nul_seen;
    logic [2:0]     r_tok_count, n_tok_count;
    logic [1:0]     r_chars, n_chars;
    logic [7:0]     r_tok_value, n_tok_value;
    logic [7:0]     r_crc, n_crc;
    logic           r_tok6_ok, n_tok6_ok;

    logic           do_close;
    logic           do_clear;
    logic           close_ok;
    logic           crc_match;
    logic [3:0]     digit;

    assign close_ok = (r_chars != 2'd0) && (r_tok_count < 3'(ahfp_pkg::FRAME_TOKENS));
    assign digit    = ahfp_pkg::hex_digit(i_byte);

    always_comb begin
        n_line_count = r_line_count;
        n_nul_seen   = r_nul_seen;
        n_tok_count  = r_tok_count;
        n_chars      = r_chars;
        n_tok_value  = r_tok_value;
        n_crc        = r_crc;
        n_tok6_ok    = r_tok6_ok;
        do_close     = 1'b0;
        do_clear     = 1'b0;
        crc_match    = r_tok6_ok;
        o_wr         = '0;
        o_res        = '0;

        if (i_accept && i_byte != ahfp_pkg::CH_CR) begin
            if (i_byte == ahfp_pkg::CH_LF) begin
                if (r_line_count != '0) begin
                    do_close  = 1'b1;
                    do_clear  = 1'b1;
                    o_res.fire = 1'b1;
                end
            end else if (r_line_count >= LINE_MAX) begin
                do_clear = 1'b1;
            end else begin
                n_line_count = r_line_count + LCW'(1);
                if (!r_nul_seen) begin
                    if (i_byte == ahfp_pkg::CH_NUL) begin
                        n_nul_seen = 1'b1;
                    end else if (i_byte == ahfp_pkg::CH_COMMA) begin
                        do_close = 1'b1;
                    end else if (r_chars == 2'd0) begin
                        n_tok_value = {digit, 4'h0};
                        n_chars     = 2'd1;
                    end else if (r_chars == 2'd1) begin
                        n_tok_value = {r_tok_value[7:4], digit};
                        n_chars     = 2'd2;
                    end
                end
            end
        end

        if (do_close) begin
            if (close_ok) begin
                if (r_tok_count < 3'(ahfp_pkg::HELD_LANES)) begin
                    o_wr.we   = 1'b1;
                    o_wr.lane = r_tok_count;
                    o_wr.data = r_tok_value;
                    n_crc     = ahfp_pkg::crc8_byte(r_crc, r_tok_value);
                end else begin
                    n_tok6_ok = (r_tok_value == r_crc);
                    crc_match = (r_tok_value == r_crc);
                end
                n_tok_count = r_tok_count + 3'd1;
            end
            n_chars     = 2'd0;
            n_tok_value = 8'h00;
        end

        if (o_res.fire) begin
            if (n_tok_count != 3'(ahfp_pkg::FRAME_TOKENS)) begin
                o_res.err = ahfp_pkg::ERR_SHORT;
            end else if (!crc_match) begin
                o_res.err = ahfp_pkg::ERR_CRC;
            end else begin
                o_res.ok  = 1'b1;
                o_res.err = ahfp_pkg::ERR_NONE;
            end
        end

        if (do_clear) begin
            n_line_count = '0;
            n_nul_seen   = 1'b0;
            n_tok_count  = 3'd0;
            n_chars      = 2'd0;
            n_tok_value  = 8'h00;
            n_crc        = ahfp_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_nul_seen   <= 1'b0;
            r_tok_count  <= 3'd0;
            r_chars      <= 2'd0;
            r_tok_value  <= 8'h00;
            r_crc        <= ahfp_pkg::CRC_INIT;
            r_tok6_ok    <= 1'b0;
        end else begin
            r_line_count <= n_line_count;
            r_nul_seen   <= n_nul_seen;
            r_tok_count  <= n_tok_count;
            r_chars      <= n_chars;
            r_tok_value  <= n_tok_value;
            r_crc        <= n_crc;
            r_tok6_ok    <= n_tok6_ok;
        end
    end

endmodule

// File: hw/rtl/ahfp_frame_store.sv
module ahfp_frame_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ahfp_pkg::t_wr_req    i_wr,
    input  logic                 i_rd_en,
    input  logic                 i_commit,
    output ahfp_pkg::t_frame_row o_held
);

    // Two rows: one holds the last good frame, the other collects the current line.
    ahfp_pkg::t_frame_row r_mem [0:1];
    ahfp_pkg::t_frame_row r_rd_data;

    logic r_commit_bank, n_commit_bank;
    logic r_held_valid, n_held_valid;
    logic r_rd_zero;

    always_comb begin
        n_commit_bank = r_commit_bank;
        n_held_valid  = r_held_valid;
        if (i_commit) begin
            n_commit_bank = ~r_commit_bank;
            n_held_valid  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[~r_commit_bank][i_wr.lane] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[n_commit_bank];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commit_bank <= 1'b0;
            r_held_valid  <= 1'b0;
            r_rd_zero     <= 1'b1;
        end else begin
            r_commit_bank <= n_commit_bank;
            r_held_valid  <= n_held_valid;
            if (i_rd_en) begin
                r_rd_zero <= ~n_held_valid;
            end
        end
    end

    assign o_held = r_rd_zero ? '0 : r_rd_data;

endmodule

// File: hw/rtl/ascii_hex_frame_parser_crc8.sv
// A result word appears in the cycle after the newline word that ends its line.
// Throughput: one input word per cycle while the sink does not hold off a waiting result;
// the byte-wise CRC and token logic and the registered frame store read set this figure.
// Reset: synchronous, active low; clears all line and token state and the held values
// read as zero until the first valid frame. The frame store itself needs no clearing.
module ascii_hex_frame_parser_crc8 #(
    parameter int LINE_BUFFER_BYTES = ahfp_pkg::LINE_BUFFER_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ahfp_in_if.sink        i_rx,
    ahfp_out_if.source     o_frame
);

    // The tokenizer works on the fly: each accepted word other than a carriage
    // return updates the line length, the open token and a running CRC-8 over tokens 0..5. Token 6 is
    // compared against the running CRC when it closes, so the CRC verdict is
    // ready at the newline without reading anything back.
    //
    // Tokens 0..5 are written into the frame store, a two-row memory. One row
    // holds the last valid frame, the other collects the current line. A valid
    // frame simply swaps the roles of the rows, and the held fields are read
    // from the committed row into the output register on the newline.

    ahfp_pkg::t_wr_req    wr_req;
    ahfp_pkg::t_result    res;
    ahfp_pkg::t_frame_row held_row;

    logic           in_accept;
    logic           r_out_valid, n_out_valid;
    logic           r_ok;
    ahfp_pkg::t_err r_err;

    // A waiting result blocks input only while the sink holds it off.
    assign i_rx.ready = !r_out_valid || o_frame.ready;
    assign in_accept  = i_rx.valid && i_rx.ready;

    ahfp_tokenizer #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_tokenizer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_byte  (i_rx.rx_byte),
        .o_wr    (wr_req),
        .o_res   (res)
    );

    ahfp_frame_store u_frame_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr_req),
        .i_rd_en (res.fire),
        .i_commit(res.fire && res.ok),
        .o_held  (held_row)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (res.fire) begin
            n_out_valid = 1'b1;
        end else if (o_frame.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Verdict registers load together with the frame store read.
    always_ff @(posedge i_clk) begin
        if (res.fire) begin
            r_ok  <= res.ok;
            r_err <= res.err;
        end
    end

    assign o_frame.valid        = r_out_valid;
    assign o_frame.frame_ok     = r_ok;
    assign o_frame.error_kind   = r_err;
    assign o_frame.flags_byte   = held_row[0];
    assign o_frame.button_bits  = {held_row[3], held_row[2], held_row[1]};
    assign o_frame.joystick_one = held_row[4];
    assign o_frame.joystick_two = held_row[5];

endmodule

// File: hw/rtl/ahfp_checker.sv
module ahfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [7:0]  i_rx_byte,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_frame_ok,
    input logic [1:0]  i_error_kind,
    input logic [23:0] i_button_bits
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // The verdict bit and the error code always agree.
    a_ok_matches_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_frame_ok == (i_error_kind == ahfp_pkg::ERR_NONE)))
        else $error("frame_ok disagrees with error_kind");

    // A fresh result follows only an accepted newline word.
    a_result_after_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !$past(i_out_valid && !i_out_ready))
        |-> $past(in_acc && i_rx_byte == ahfp_pkg::CH_LF))
        else $error("result without a preceding newline");

    // With no result pending, input is never held off.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // A stalled result keeps its held fields.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_button_bits)))
        else $error("stalled result changed");

endmodule

bind ascii_hex_frame_parser_crc8 ahfp_checker u_ahfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_rx.valid),
    .i_in_ready   (i_rx.ready),
    .i_rx_byte    (i_rx.rx_byte),
    .i_out_valid  (o_frame.valid),
    .i_out_ready  (o_frame.ready),
    .i_frame_ok   (o_frame.frame_ok),
    .i_error_kind (o_frame.error_kind),
    .i_button_bits(o_frame.button_bits)
);
